/* rtl/servo_bus_status_deframer_unit_defines.svh */
// Assertion macros used by the deframer control module.
// Each macro checks on the rising edge of i_clk and is silent while i_rst_n is low.
`ifndef SERVO_BUS_STATUS_DEFRAMER_UNIT_DEFINES_SVH
`define SERVO_BUS_STATUS_DEFRAMER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbsd_pkg.sv */
package sbsd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 5);
    localparam int PLEN_W      = 6;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_HDR   = 2'd2,
        ST_CSUM  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    // Register index as decoded from paddr[2].
    typedef enum logic {
        REG_EXPECTED_ID = 1'b0,
        REG_PAYLOAD_LEN = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        expected_id;
        logic [PLEN_W-1:0] payload_len;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    // Payload length as used by the frame: zero counts as one, and the value is
    // capped at the store depth.
    function automatic logic [LEN_W-1:0] eff_len(input logic [PLEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        if (len == '0) begin
            n = LEN_W'(1);
        end else if (int'(len) > MAX_PAYLOAD) begin
            n = LEN_W'(MAX_PAYLOAD);
        end else begin
            n = LEN_W'(len);
        end
        return n;
    endfunction

endpackage

/* rtl/sbsd_cfg.sv */
module sbsd_cfg
    import sbsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_id <= 8'd1;
            r_cfg.payload_len <= PLEN_W'(1);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_EXPECTED_ID: r_cfg.expected_id <= pwdata[7:0];
                REG_PAYLOAD_LEN: r_cfg.payload_len <= pwdata[PLEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_EXPECTED_ID: prdata = PDATA_W'(r_cfg.expected_id);
            REG_PAYLOAD_LEN: prdata = PDATA_W'(r_cfg.payload_len);
        endcase
    end

endmodule

/* rtl/sbsd_store.sv */
module sbsd_store
    import sbsd_pkg::*;
(
    input  logic              i_clk,
    input  t_store_wr         i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [MAX_PAYLOAD];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/sbsd_ctrl.sv */
`include "servo_bus_status_deframer_unit_defines.svh"

module sbsd_ctrl
    import sbsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    output t_store_wr         o_wr,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [7:0]        r_sum, n_sum;
    logic              r_hdr_bad, n_hdr_bad;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_last_idx, n_last_idx;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [LEN_W-1:0]  w_len;
    logic [CNT_W-1:0]  w_final_pos;
    logic [CNT_W-1:0]  w_off;
    logic [7:0]        w_len_byte;
    logic [7:0]        w_byte;
    logic              w_accept;
    logic              w_out_free;
    logic              w_is_final;
    logic              w_hdr_miss;
    logic              w_csum_ok;
    logic              w_good_end;
    logic              w_load;

    assign w_len       = eff_len(i_cfg.payload_len);
    assign w_final_pos = CNT_W'(w_len) + CNT_W'(4);
    assign w_off       = r_byte_cnt - CNT_W'(4);
    assign w_len_byte  = 8'(w_len) + 8'd1;
    assign w_byte      = i_in_data.rx_byte;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_is_final  = (r_byte_cnt >= w_final_pos);
    assign w_csum_ok   = (w_byte == ~r_sum);
    assign w_good_end  = w_accept && !i_in_data.op && w_is_final && !r_hdr_bad && w_csum_ok;

    always_comb begin
        w_hdr_miss = 1'b0;
        if (r_byte_cnt < CNT_W'(2)) begin
            w_hdr_miss = (w_byte != SYNC_BYTE);
        end else if (r_byte_cnt == CNT_W'(2)) begin
            w_hdr_miss = (w_byte != i_cfg.expected_id);
        end else if (r_byte_cnt == CNT_W'(3)) begin
            w_hdr_miss = (w_byte != w_len_byte);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_good_end) begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (w_out_free) begin
                    n_state = (r_idx == r_last_idx) ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        o_in_ready  = 1'b0;
        w_load      = 1'b0;
        n_out       = r_out;
        n_byte_cnt  = r_byte_cnt;
        n_sum       = r_sum;
        n_hdr_bad   = r_hdr_bad;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        o_wr.en     = 1'b0;
        o_wr.addr   = w_off[ADDR_W-1:0];
        o_wr.data   = w_byte;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = w_out_free;
                if (w_accept) begin
                    if (i_in_data.op) begin
                        w_load     = 1'b1;
                        n_out      = '{status: ST_SHORT, data_byte: 8'd0, last: 1'b1};
                        n_byte_cnt = '0;
                        n_sum      = '0;
                        n_hdr_bad  = 1'b0;
                    end else if (w_is_final) begin
                        n_byte_cnt = '0;
                        n_sum      = '0;
                        n_hdr_bad  = 1'b0;
                        n_idx      = '0;
                        n_last_idx = ADDR_W'(w_len - LEN_W'(1));
                        if (r_hdr_bad) begin
                            w_load = 1'b1;
                            n_out  = '{status: ST_HDR, data_byte: 8'd0, last: 1'b1};
                        end else if (!w_csum_ok) begin
                            w_load = 1'b1;
                            n_out  = '{status: ST_CSUM, data_byte: 8'd0, last: 1'b1};
                        end
                    end else begin
                        n_hdr_bad  = r_hdr_bad || w_hdr_miss;
                        n_byte_cnt = r_byte_cnt + CNT_W'(1);
                        if (r_byte_cnt >= CNT_W'(2)) begin
                            n_sum = r_sum + w_byte;
                        end
                        if ((r_byte_cnt >= CNT_W'(4)) && (w_off < CNT_W'(w_len))) begin
                            o_wr.en = 1'b1;
                        end
                    end
                end
            end
            S_EMIT_RD: begin
            end
            S_EMIT_OUT: begin
                // The store registered its read of r_idx in S_EMIT_RD, so its read data is current.
                if (w_out_free) begin
                    w_load = 1'b1;
                    n_out  = '{status: ST_OK, data_byte: i_rd_data,
                               last: (r_idx == r_last_idx)};
                    n_idx  = r_idx + ADDR_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_byte_cnt  <= '0;
            r_sum       <= '0;
            r_hdr_bad   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_byte_cnt  <= n_byte_cnt;
            r_sum       <= n_sum;
            r_hdr_bad   <= n_hdr_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_out      <= n_out;
    end

    assign o_rd_addr   = r_idx;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SBSD_ASSERT_NOW(a_wr_only_on_byte, o_wr.en, w_accept && !i_in_data.op && !w_is_final, "store written outside a payload byte transfer")
    `SBSD_ASSERT_NOW(a_idx_in_frame, r_state == S_EMIT_RD || r_state == S_EMIT_OUT, r_idx <= r_last_idx, "emission index ran past the frame payload")
    `SBSD_ASSERT_NEXT(a_last_ends_emit, r_state == S_EMIT_OUT && w_load && n_out.last, r_state == S_IDLE, "emission continued after the last payload byte")
    `SBSD_ASSERT_NOW(a_err_zero_data, r_out_valid && r_out.status != ST_OK, r_out.data_byte == 8'd0 && r_out.last, "error result with data or without last flag")

endmodule

/* rtl/servo_bus_status_deframer_unit.sv */
// Errors: a received byte that ends a bad or short frame shows its error result in the next cycle.
// A good frame shows its first payload byte after the checksum byte, via S_EMIT_RD and S_EMIT_OUT.
// Throughput: one input byte per cycle while idle with the output free; each payload byte passes
// S_EMIT_RD, where the store registers its read, then S_EMIT_OUT; no input is taken while it runs.
// Reset: synchronous, active low; clears the frame state and the output valid, and sets
// expected_id and payload_len to 1. The payload store is not cleared and needs no clearing pass.
module servo_bus_status_deframer_unit
    import sbsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data
);

    t_cfg              w_cfg;
    t_store_wr         w_wr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [7:0]        w_rd_data;

    sbsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sbsd_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sbsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_wr        (w_wr),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

endmodule
